// ----- src/anbs_pkg.sv -----
// ----------------------------------------------------------------------------
// Annex B NAL unit splitter package
// Shared result and burst types and byte constants of the splitter.
// ----------------------------------------------------------------------------
package anbs_pkg;

  localparam int MaxRes = 5;
  localparam int CntW   = 3;
  localparam int QDepth = 4;
  localparam int QPtrW  = 2;

  localparam logic [7:0] ZeroByte = 8'h00;
  localparam logic [7:0] CodeByte = 8'h01;

  typedef struct packed {
    logic [7:0] nal_byte;
    logic       first_of_unit;
    logic       last_of_unit;
    logic       empty_unit;
  } res_t;

  typedef struct packed {
    logic [CntW-1:0]       cnt;
    res_t [MaxRes-1:0]     res;
  } burst_t;

  function automatic res_t make_res(logic [7:0] b, logic f, logic l, logic e);
    res_t r;
    r.nal_byte      = b;
    r.first_of_unit = f;
    r.last_of_unit  = l;
    r.empty_unit    = e;
    return r;
  endfunction

endpackage

// ----- src/anbs_front.sv -----
// ----------------------------------------------------------------------------
// Splitter front end
// Accepts bytes, tracks start codes and builds the burst of results per byte.
// ----------------------------------------------------------------------------
module anbs_front
  import anbs_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic       cfg_wdata,
  input  logic       in_valid,
  input  logic       in_stall,
  input  logic [7:0] data_byte,
  input  logic       end_of_packet,
  output logic       push,
  output burst_t     burst
);

  logic       split_mode;
  logic       inside_unit;
  logic       held_valid;
  logic [7:0] held_byte;
  logic [1:0] zero_run;
  logic       first_pending;

  logic       inside_unit_next;
  logic       held_valid_next;
  logic [7:0] held_byte_next;
  logic [1:0] zero_run_next;
  logic       first_pending_next;
  logic       accept;

  assign accept = in_valid && !in_stall;

  always_comb begin
    logic            iu;
    logic            hv;
    logic [7:0]      hb;
    logic [1:0]      zr;
    logic            fp;
    logic [CntW-1:0] n;
    logic            is_code;
    iu      = inside_unit;
    hv      = held_valid;
    hb      = held_byte;
    zr      = zero_run;
    fp      = first_pending;
    n       = '0;
    burst   = '0;
    is_code = (data_byte == CodeByte) && (zr >= 2'd2);
    if (!split_mode) begin
      burst.res[0] = make_res(data_byte, !iu, end_of_packet, 1'b0);
      n  = CntW'(1);
      iu = !end_of_packet;
    end else begin
      if (!iu) begin
        if (is_code) begin
          iu = 1'b1;
          hv = 1'b0;
          hb = ZeroByte;
          zr = 2'd0;
          fp = 1'b1;
        end else if (data_byte == ZeroByte) begin
          if (zr != 2'd3) zr = zr + 2'd1;
        end else begin
          zr = 2'd0;
        end
      end else if (is_code) begin
        if (hv) begin
          burst.res[n] = make_res(hb, fp, 1'b1, 1'b0);
        end else begin
          burst.res[n] = make_res(ZeroByte, 1'b1, 1'b1, 1'b1);
        end
        n  = n + CntW'(1);
        iu = 1'b1;
        hv = 1'b0;
        hb = ZeroByte;
        zr = 2'd0;
        fp = 1'b1;
      end else if (data_byte == ZeroByte) begin
        if (zr != 2'd3) begin
          zr = zr + 2'd1;
        end else begin
          if (hv) begin
            burst.res[n] = make_res(hb, fp, 1'b0, 1'b0);
            n  = n + CntW'(1);
            fp = 1'b0;
          end
          hb = ZeroByte;
          hv = 1'b1;
        end
      end else begin
        if (hv) begin
          burst.res[n] = make_res(hb, fp, 1'b0, 1'b0);
          n  = n + CntW'(1);
          fp = 1'b0;
        end
        for (int k = 0; k < 3; k++) begin
          if (2'(k) < zr) begin
            burst.res[n] = make_res(ZeroByte, fp, 1'b0, 1'b0);
            n  = n + CntW'(1);
            fp = 1'b0;
          end
        end
        hb = data_byte;
        hv = 1'b1;
        zr = 2'd0;
      end
      if (end_of_packet) begin
        if (iu) begin
          if (!hv && zr == 2'd0) begin
            burst.res[n] = make_res(ZeroByte, 1'b1, 1'b1, 1'b1);
            n  = n + CntW'(1);
            fp = 1'b0;
          end else begin
            if (hv) begin
              burst.res[n] = make_res(hb, fp, zr == 2'd0, 1'b0);
              n  = n + CntW'(1);
              fp = 1'b0;
            end
            for (int k = 0; k < 3; k++) begin
              if (2'(k) < zr) begin
                burst.res[n] = make_res(ZeroByte, fp, 2'(k) == zr - 2'd1, 1'b0);
                n  = n + CntW'(1);
                fp = 1'b0;
              end
            end
          end
        end
        iu = 1'b0;
        hv = 1'b0;
        hb = ZeroByte;
        zr = 2'd0;
        fp = 1'b0;
      end
    end
    burst.cnt          = n;
    push               = accept && (n != '0);
    inside_unit_next   = iu;
    held_valid_next    = hv;
    held_byte_next     = hb;
    zero_run_next      = zr;
    first_pending_next = fp;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      split_mode    <= 1'b1;
      inside_unit   <= 1'b0;
      held_valid    <= 1'b0;
      held_byte     <= ZeroByte;
      zero_run      <= 2'd0;
      first_pending <= 1'b0;
    end else if (cfg_we) begin
      split_mode    <= cfg_wdata;
      inside_unit   <= 1'b0;
      held_valid    <= 1'b0;
      held_byte     <= ZeroByte;
      zero_run      <= 2'd0;
      first_pending <= 1'b0;
    end else if (accept) begin
      inside_unit   <= inside_unit_next;
      held_valid    <= held_valid_next;
      held_byte     <= held_byte_next;
      zero_run      <= zero_run_next;
      first_pending <= first_pending_next;
    end
  end

endmodule

// ----- src/anbs_fifo.sv -----
// ----------------------------------------------------------------------------
// Splitter burst queue
// Short queue of result bursts between the front end and the output stage.
// ----------------------------------------------------------------------------
module anbs_fifo
  import anbs_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  logic   push,
  input  burst_t push_data,
  input  logic   pop,
  output logic   full,
  output logic   head_valid,
  output burst_t head
);

  burst_t               mem [QDepth];
  logic [QPtrW-1:0]     wr_ptr;
  logic [QPtrW-1:0]     rd_ptr;
  logic [QPtrW:0]       count;
  logic                 do_pop;

  assign full       = (count == (QPtrW+1)'(QDepth));
  assign head_valid = (count != '0);
  assign head       = mem[rd_ptr];
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + QPtrW'(1);
      if (do_pop) rd_ptr <= rd_ptr + QPtrW'(1);
      count <= count + (QPtrW+1)'(push) - (QPtrW+1)'(do_pop);
    end
  end

endmodule

// ----- src/anbs_back.sv -----
// ----------------------------------------------------------------------------
// Splitter output stage
// Steps through the results of the burst at the queue head, one per cycle while out_stall is low.
// ----------------------------------------------------------------------------
module anbs_back
  import anbs_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       head_valid,
  input  burst_t     head,
  output logic       pop,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] nal_byte,
  output logic       first_of_unit,
  output logic       last_of_unit,
  output logic       empty_unit,
  output logic       last_of_burst
);

  logic [CntW-1:0] idx;
  logic            fire;
  res_t            cur;

  assign cur           = head.res[idx];
  assign out_valid     = head_valid;
  assign nal_byte      = cur.nal_byte;
  assign first_of_unit = cur.first_of_unit;
  assign last_of_unit  = cur.last_of_unit;
  assign empty_unit    = cur.empty_unit;
  assign last_of_burst = (idx == head.cnt - CntW'(1));
  assign fire          = out_valid && !out_stall;
  assign pop           = fire && last_of_burst;

  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
    end else if (fire) begin
      if (last_of_burst) idx <= '0;
      else idx <= idx + CntW'(1);
    end
  end

endmodule

// ----- src/annexb_nal_unit_splitter.sv -----
// ----------------------------------------------------------------------------
// Annex B NAL unit splitter
// Cuts a byte stream of encoded packets into NAL units at start codes.
// ----------------------------------------------------------------------------
// The input channel carries one packet byte per transaction with an
// end_of_packet mark on its last byte. The output channel carries one unit
// byte per transaction, marked first or last of its unit; a zero-length unit
// appears as one transaction with empty_unit set. last_of_burst marks the
// final result caused by one input byte.
// The front end takes one byte per cycle while the queue is not full and
// turns it into a burst of zero to five results, which waits in a
// four-entry queue. The output stage sends one result per cycle while the
// receiver does not stall; a byte's results appear once its burst reaches
// the queue head. Since results roughly equal bytes, the sustained rate is
// one byte per cycle; in_stall rises only when the queue holds four bursts.
// When the receiver stalls, the current result holds and bytes keep being
// taken until the queue fills. Reset empties the queue, clears the stream
// state and sets split mode. A write of cfg_wdata sets split_mode and
// starts a new packet.
// ----------------------------------------------------------------------------
module annexb_nal_unit_splitter
  import anbs_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic       cfg_wdata,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] data_byte,
  input  logic       end_of_packet,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] nal_byte,
  output logic       first_of_unit,
  output logic       last_of_unit,
  output logic       empty_unit,
  output logic       last_of_burst
);

  logic   push;
  burst_t push_data;
  logic   pop;
  logic   full;
  logic   head_valid;
  burst_t head;

  assign in_stall = full;

  anbs_front u_front (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .data_byte     (data_byte),
    .end_of_packet (end_of_packet),
    .push          (push),
    .burst         (push_data)
  );

  anbs_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_data  (push_data),
    .pop        (pop),
    .full       (full),
    .head_valid (head_valid),
    .head       (head)
  );

  anbs_back u_back (
    .clk           (clk),
    .rst           (rst),
    .head_valid    (head_valid),
    .head          (head),
    .pop           (pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .nal_byte      (nal_byte),
    .first_of_unit (first_of_unit),
    .last_of_unit  (last_of_unit),
    .empty_unit    (empty_unit),
    .last_of_burst (last_of_burst)
  );

endmodule

// ----- src/anbs_checker.sv -----
// ----------------------------------------------------------------------------
// Annex B NAL unit splitter checker
// Port-level checks of the splitter, bound to the top level.
// ----------------------------------------------------------------------------
module anbs_checker (
  input logic       clk,
  input logic       rst,
  input logic       cfg_we,
  input logic       cfg_wdata,
  input logic       in_valid,
  input logic       in_stall,
  input logic [7:0] data_byte,
  input logic       end_of_packet,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] nal_byte,
  input logic       first_of_unit,
  input logic       last_of_unit,
  input logic       empty_unit,
  input logic       last_of_burst
);

  a_reset_idle: assert property (@(posedge clk) rst |=> !out_valid && !in_stall)
    else $error("splitter not idle after reset");

  a_empty_marker: assert property (@(posedge clk) disable iff (rst)
    (out_valid && empty_unit) |-> (first_of_unit && last_of_unit && nal_byte == 8'h00))
    else $error("empty unit marker malformed");

  a_burst_continues: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_stall && !last_of_burst) |=> out_valid)
    else $error("burst broken off before its last result");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(nal_byte) && $stable(last_of_burst)))
    else $error("stalled result changed");

endmodule

bind annexb_nal_unit_splitter anbs_checker u_anbs_checker (.*);
